FILE: hdl/masked_byte_pattern_search_defines.svh
// assertion macros shared by the pattern search rtl
`ifndef MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MBPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MBPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mbps_pkg.sv
// shared constants and types of the masked byte pattern search
package mbps_pkg;

    localparam int PAT_BYTES      = 32;
    localparam int IDX_W          = $clog2(PAT_BYTES);
    localparam int LEN_W          = 6;
    localparam int WIN_DEPTH      = PAT_BYTES - 1;
    localparam int DATA_W         = 8;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int PAT_WORDS      = PAT_BYTES / (CFG_W / DATA_W);
    localparam int PAT_WORD_IDX_W = $clog2(PAT_WORDS);
    localparam int MASK_W         = 32;
    localparam int OFF_W          = 32;
    localparam int OUT_OFF_W      = 32;
    localparam int ADDR_W         = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT0 = 3'd0,
        CFG_PAT1 = 3'd1,
        CFG_PAT2 = 3'd2,
        CFG_PAT3 = 3'd3,
        CFG_MASK = 3'd4,
        CFG_LEN  = 3'd5,
        CFG_BASE = 3'd6
    } t_cfg_idx;

    // window shift control handed to every cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

endpackage

FILE: hdl/mbps_in_if.sv
// byte stream channel into the pattern search
interface mbps_in_if;
    logic                        valid;
    logic                        ready;
    logic [mbps_pkg::DATA_W-1:0] data_byte;
    logic                        last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hdl/mbps_out_if.sv
// search result channel out of the pattern search
interface mbps_out_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [mbps_pkg::OUT_OFF_W-1:0] match_offset;
    logic [mbps_pkg::ADDR_W-1:0]    match_address;

    modport source (output valid, output found, output match_offset, output match_address,
                    input ready);
    modport sink   (input valid, input found, input match_offset, input match_address,
                    output ready);
endinterface

FILE: hdl/mbps_cell.sv
// one window cell: compares the byte passing through and holds it for the next age
module mbps_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbps_pkg::t_win_ctl          i_ctl,
    input  logic [mbps_pkg::DATA_W-1:0] i_byte,
    input  logic [mbps_pkg::DATA_W-1:0] i_pat_byte,
    input  logic                        i_care,
    output logic [mbps_pkg::DATA_W-1:0] o_byte,
    output logic                        o_hit
);

    logic [mbps_pkg::DATA_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_byte <= '0;
        end else if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    // wildcard or equal at this age
    assign o_hit  = !i_care || (i_byte == i_pat_byte);
    assign o_byte = r_byte;

endmodule

FILE: hdl/masked_byte_pattern_search.sv
// top level of the masked byte pattern search
//
// usage
//   i_in carries one buffer byte per transaction, last_byte marks the final byte.
//   o_out carries at most one result per buffer: found=1 with the offset of the
//   first byte of the first match and base_address plus that offset, or found=0
//   on the last byte when the buffer held no match. bytes after a match are
//   absorbed without result.
//   the pattern registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while no transaction is in flight.
// timing
//   one byte per cycle sustained while i_in is open. the window compare is done in the
//   cycle the byte is accepted; the result is registered into the output register, or
//   into the skid register while the output register waits. this two-entry output queue
//   keeps i_in open while one result waits; i_in only stalls when both entries are full.
// reset
//   synchronous active low: window, offset counter and queue clear, pattern and
//   mask clear, pattern_length returns to 1, base_address to 0.
`include "masked_byte_pattern_search_defines.svh"

module masked_byte_pattern_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mbps_in_if.sink                        i_in,
    mbps_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mbps_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int PAT_BYTES = mbps_pkg::PAT_BYTES;
    localparam int WIN_DEPTH = mbps_pkg::WIN_DEPTH;
    localparam int IDX_W     = mbps_pkg::IDX_W;
    localparam int DATA_W    = mbps_pkg::DATA_W;
    localparam int CFG_W     = mbps_pkg::CFG_W;
    localparam int LEN_W     = mbps_pkg::LEN_W;
    localparam int OFF_W     = mbps_pkg::OFF_W;
    localparam int OUT_OFF_W = mbps_pkg::OUT_OFF_W;
    localparam int ADDR_W    = mbps_pkg::ADDR_W;
    localparam int MASK_W    = mbps_pkg::MASK_W;
    localparam int PAT_WORDS = mbps_pkg::PAT_WORDS;
    localparam int BYTE_SH   = $clog2(DATA_W);

    typedef struct packed {
        logic                 found;
        logic [OUT_OFF_W-1:0] offset;
    } t_result;

    // configuration registers
    logic [CFG_W-1:0]  r_pat [PAT_WORDS];
    logic [MASK_W-1:0] r_mask;
    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_base;

    // per-buffer state
    logic [OFF_W-1:0]  r_pos;
    logic              r_reported;

    // output queue
    logic    r_out_v, n_out_v;
    logic    r_skid_v, n_skid_v;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    logic [PAT_BYTES*DATA_W-1:0] w_pat_flat;
    logic [IDX_W-1:0]            w_len_m1;
    logic [DATA_W-1:0]           w_al_byte [PAT_BYTES];
    logic [PAT_BYTES-1:0]        w_al_care;
    logic [DATA_W-1:0]           w_win [WIN_DEPTH+1];
    logic [WIN_DEPTH-1:0]        w_cell_hit;
    logic                        w_tail_hit;
    logic                        w_hit_all;
    logic                        w_acc;
    logic                        w_match;
    logic                        w_res_v;
    logic                        w_pop;
    t_result                     w_res;
    mbps_pkg::t_win_ctl          w_ctl;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pat[w] <= '0;
            end
            r_mask <= '0;
            r_len  <= LEN_W'(1);
            r_base <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                mbps_pkg::CFG_PAT0, mbps_pkg::CFG_PAT1,
                mbps_pkg::CFG_PAT2, mbps_pkg::CFG_PAT3: begin
                    r_pat[i_cfg_idx[mbps_pkg::PAT_WORD_IDX_W-1:0]] <= i_cfg_data;
                end
                mbps_pkg::CFG_MASK: r_mask <= i_cfg_data[MASK_W-1:0];
                mbps_pkg::CFG_LEN:  r_len  <= i_cfg_data[LEN_W-1:0];
                mbps_pkg::CFG_BASE: r_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pattern length minus one, with zero taken as one and overlong as full
    always_comb begin
        if (r_len == '0) begin
            w_len_m1 = '0;
        end else if (r_len > LEN_W'(PAT_BYTES)) begin
            w_len_m1 = IDX_W'(PAT_BYTES - 1);
        end else begin
            w_len_m1 = IDX_W'(r_len - LEN_W'(1));
        end
    end

    always_comb begin
        for (int w = 0; w < PAT_WORDS; w++) begin
            w_pat_flat[w*CFG_W +: CFG_W] = r_pat[w];
        end
    end

    // align the pattern to window ages: age a meets pattern byte len-1-a,
    // ages at or beyond the length never care
    always_comb begin
        logic [IDX_W-1:0] v_idx;
        v_idx = '0;
        for (int a = 0; a < PAT_BYTES; a++) begin
            v_idx        = w_len_m1 - IDX_W'(a);
            w_al_byte[a] = w_pat_flat[{v_idx, BYTE_SH'(0)} +: DATA_W];
            w_al_care[a] = (IDX_W'(a) <= w_len_m1) && r_mask[v_idx];
        end
    end

    // ---------------- window chain ----------------
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_ctl.shift = w_acc && !i_in.last_byte;
    assign w_ctl.clear = w_acc && i_in.last_byte;
    assign w_win[0]    = i_in.data_byte;

    // cell g compares the byte of age g and holds it as age g+1
    for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
        mbps_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_byte     (w_win[g]),
            .i_pat_byte (w_al_byte[g]),
            .i_care     (w_al_care[g]),
            .o_byte     (w_win[g+1]),
            .o_hit      (w_cell_hit[g])
        );
    end

    // oldest age sits at the end of the chain
    assign w_tail_hit = !w_al_care[WIN_DEPTH] || (w_win[WIN_DEPTH] == w_al_byte[WIN_DEPTH]);
    assign w_hit_all  = (&w_cell_hit) && w_tail_hit;

    // ---------------- match decision ----------------
    // a match needs at least len bytes of this buffer, counting the current one
    assign w_match = !r_reported && (r_pos >= OFF_W'(w_len_m1)) && w_hit_all;
    assign w_res_v = w_acc && !r_reported && (w_match || i_in.last_byte);

    always_comb begin
        w_res.found  = w_match;
        w_res.offset = w_match ? OUT_OFF_W'(r_pos - OFF_W'(w_len_m1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_reported <= 1'b0;
        end else if (w_acc) begin
            if (i_in.last_byte) begin
                r_pos      <= '0;
                r_reported <= 1'b0;
            end else begin
                // offset counter saturates
                if (r_pos != '1) begin
                    r_pos <= r_pos + OFF_W'(1);
                end
                r_reported <= r_reported || w_match;
            end
        end
    end

    // ---------------- output queue ----------------
    assign w_pop      = r_out_v && o_out.ready;
    assign i_in.ready = !r_skid_v;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (r_skid_v) begin
            // input is closed, drain skid into the output register
            if (w_pop) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (w_res_v) begin
            if (!r_out_v || w_pop) begin
                n_out_v = 1'b1;
                n_out   = w_res;
            end else begin
                n_skid_v = 1'b1;
                n_skid   = w_res;
            end
        end else if (w_pop) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // the user changes the base address only while nothing is queued; the block itself does not enforce it
    assign o_out.valid         = r_out_v;
    assign o_out.found         = r_out.found;
    assign o_out.match_offset  = r_out.offset;
    assign o_out.match_address = r_out.found ? (r_base + ADDR_W'(r_out.offset)) : '0;

    // ---------------- assertions ----------------
    `MBPS_ASSERT_IMP(a_skid_behind_out, r_skid_v, r_out_v, "skid entry without output entry")
    `MBPS_ASSERT_NXT(a_last_clears, w_acc && i_in.last_byte, (r_pos == '0) && !r_reported, "buffer state not cleared after last byte")
    `MBPS_ASSERT_NXT(a_match_marks, w_acc && w_match && !i_in.last_byte, r_reported, "match not recorded as reported")
    `MBPS_ASSERT_IMP(a_one_result, w_acc && r_reported, !w_res_v, "second result in one buffer")

endmodule

FILE: tb/masked_byte_pattern_search_tb.sv
// self-checking testbench for the masked byte pattern search
`timescale 1ns / 100ps

module masked_byte_pattern_search_tb;

    localparam int DATA_W    = mbps_pkg::DATA_W;
    localparam int OUT_OFF_W = mbps_pkg::OUT_OFF_W;
    localparam int ADDR_W    = mbps_pkg::ADDR_W;
    localparam int CFG_W     = mbps_pkg::CFG_W;
    localparam int PAT_WORDS = mbps_pkg::PAT_WORDS;
    localparam int MASK_W    = mbps_pkg::MASK_W;
    localparam int LEN_W     = mbps_pkg::LEN_W;
    localparam int WIN_DEPTH = mbps_pkg::WIN_DEPTH;
    localparam int OFF_W     = mbps_pkg::OFF_W;
    localparam int PAT_BYTES = mbps_pkg::PAT_BYTES;

    // run sizing
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 145;
    localparam int MAX_WAIT        = 10;      // longest per-transaction gap on either side
    localparam int LONG_HOLD       = 300;     // receiver back-pressure stretch
    localparam int IDLE_GAP        = 4;       // settle time before a register write
    localparam int DRAIN_CYCLES    = 16;      // extra cycles after the last result
    localparam int CYCLE_LIMIT     = 300000;
    localparam int MAX_PRINTS      = 50;

    // one byte of the scanned buffer, as queued for the driver
    typedef struct {
        logic [DATA_W-1:0] data;
        logic              last;
    } t_stream_byte;

    // one search result, as the block should report it
    typedef struct packed {
        logic                 found;
        logic [OUT_OFF_W-1:0] match_offset;
        logic [ADDR_W-1:0]    match_address;
    } t_search_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    mbps_pkg::t_cfg_idx cfg_idx;
    logic [CFG_W-1:0]   cfg_data;

    mbps_in_if  byte_if ();
    mbps_out_if result_if ();

    masked_byte_pattern_search uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (byte_if),
        .o_out      (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // stimulus and expectation stores
    t_stream_byte      byte_q[$];         // bytes waiting for the driver
    logic [DATA_W-1:0] frame_q[$];        // one buffer being assembled
    t_search_result    result_q[$];       // results still owed by the block

    // shadow of the configuration registers
    logic [CFG_W-1:0]  pat_word[PAT_WORDS];
    logic [MASK_W-1:0] pat_mask;
    logic [LEN_W-1:0]  pat_len;
    logic [ADDR_W-1:0] base_addr;

    // shadow of the per-buffer search state
    logic [DATA_W-1:0] history[WIN_DEPTH];   // newest byte first
    logic [OFF_W-1:0]  seen_cnt;
    logic              reported;

    // handshake pacing controls; the calm flags and hold requests are written by the stimulus at falling edges
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    int hold_req = 0;
    int hold_done;
    int gap_left;
    int stall_left;

    int mismatch_cnt = 0;
    int cycle_cnt = 0;

    // clock, and every block input known from time zero
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = mbps_pkg::CFG_PAT0;
        cfg_data = '0;
        byte_if.valid = 1'b0;
        byte_if.data_byte = '0;
        byte_if.last_byte = 1'b0;
        result_if.ready = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // -------------------------------------------------------------------
    // predictor
    // -------------------------------------------------------------------

    // pattern length actually in use: 0 reads as 1, above 32 clamps to 32
    function automatic int unsigned used_length();
        if (pat_len == 0) return 1;
        if (pat_len > PAT_BYTES) return PAT_BYTES;
        return pat_len;
    endfunction

    // compare the n newest bytes (newest = d) with the pattern, honoring wildcards
    function automatic bit pattern_hit(logic [DATA_W-1:0] d, int unsigned n);
        int unsigned age;
        logic [DATA_W-1:0] b;
        for (int unsigned i = 0; i < n; i++) begin
            age = n - 1 - i;
            b = (age == 0) ? d : history[age - 1];
            if (pat_mask[i] && b != pat_word[i >> 3][8 * (i & 7) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // window, offset counter and report flag go back to zero between buffers
    function automatic void clear_search();
        foreach (history[k]) history[k] = '0;
        seen_cnt = '0;
        reported = 1'b0;
    endfunction

    // take in one accepted byte and queue the result it causes, if any
    function automatic void absorb_byte(logic [DATA_W-1:0] d, logic last);
        int unsigned n;
        logic [OFF_W-1:0] off;
        t_search_result r;
        n = used_length();
        if (!reported && seen_cnt >= n - 1 && pattern_hit(d, n)) begin
            // first match of this buffer, offset zero included
            off = seen_cnt - (n - 1);
            r.found = 1'b1;
            r.match_offset = off;
            r.match_address = base_addr + off;
            result_q = {result_q, r};
            reported = 1'b1;
        end else if (!reported && last) begin
            // buffer ended without a match
            r = '0;
            result_q = {result_q, r};
        end
        if (last) begin
            clear_search();
        end else begin
            for (int k = WIN_DEPTH - 1; k > 0; k--) history[k] = history[k - 1];
            history[0] = d;
            if (seen_cnt != '1) seen_cnt = seen_cnt + 1;   // offset counter saturates
        end
    endfunction

    // -------------------------------------------------------------------
    // driver: one byte per transaction, random gap after each
    // -------------------------------------------------------------------

    always @(posedge i_clk) begin : byte_driver
        t_stream_byte pend;
        if (!i_rst_n) begin
            byte_if.valid <= 1'b0;
            gap_left <= 0;
        end else if (!byte_if.valid || byte_if.ready) begin
            if (gap_left != 0) begin
                byte_if.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (byte_q.size() != 0) begin
                pend = byte_q.pop_front();
                byte_if.valid <= 1'b1;
                byte_if.data_byte <= pend.data;
                byte_if.last_byte <= pend.last;
                gap_left <= tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end else begin
                byte_if.valid <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------------------
    // result receiver: random stall after each transaction, plus long holds
    // -------------------------------------------------------------------

    always @(posedge i_clk) begin : result_receiver
        int w;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            stall_left <= 0;
            hold_done <= 0;
        end else if (stall_left != 0) begin
            result_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (hold_done != hold_req) begin
            // long back-pressure: output queue fills and the byte input stalls
            result_if.ready <= 1'b0;
            stall_left <= LONG_HOLD - 1;
            hold_done <= hold_done + 1;
        end else if (result_if.valid && result_if.ready) begin
            w = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            result_if.ready <= (w == 0);
            stall_left <= (w == 0) ? 0 : w - 1;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // -------------------------------------------------------------------
    // monitor: predict on each byte transaction, check each result transaction
    // -------------------------------------------------------------------

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        if (mismatch_cnt < MAX_PRINTS)
            $display("cycle %0d: %s mismatch, got %0h, expected %0h",
                     cycle_cnt, field, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_search_result want;
        if (i_rst_n) begin
            if (byte_if.valid && byte_if.ready)
                absorb_byte(byte_if.data_byte, byte_if.last_byte);
            if (result_if.valid && result_if.ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result, found", result_if.found, 0);
                end else begin
                    want = result_q.pop_front();
                    if (result_if.found !== want.found)
                        report_mismatch("found", result_if.found, want.found);
                    if (result_if.match_offset !== want.match_offset)
                        report_mismatch("match_offset", result_if.match_offset,
                                        want.match_offset);
                    if (result_if.match_address !== want.match_address)
                        report_mismatch("match_address", result_if.match_address,
                                        want.match_address);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("masked_byte_pattern_search test failed");
            $finish;
        end
    end

    // -------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------

    // register write: one cycle with the write enable high, shadow updated alongside
    task automatic write_reg(mbps_pkg::t_cfg_idx idx, logic [CFG_W-1:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        case (idx)
            mbps_pkg::CFG_PAT0: pat_word[0] = value;
            mbps_pkg::CFG_PAT1: pat_word[1] = value;
            mbps_pkg::CFG_PAT2: pat_word[2] = value;
            mbps_pkg::CFG_PAT3: pat_word[3] = value;
            mbps_pkg::CFG_MASK: pat_mask = value[MASK_W-1:0];
            mbps_pkg::CFG_LEN:  pat_len = value[LEN_W-1:0];
            mbps_pkg::CFG_BASE: base_addr = value;
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // block is idle: nothing queued or offered, every result back, pipeline settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || byte_if.valid || result_q.size() != 0);
        repeat (IDLE_GAP) @(negedge i_clk);
    endtask

    // hand the assembled buffer to the driver, last_byte on its final byte
    function automatic void push_frame();
        t_stream_byte s;
        foreach (frame_q[k]) begin
            s.data = frame_q[k];
            s.last = (k == frame_q.size() - 1);
            byte_q = {byte_q, s};
        end
        frame_q.delete();
    endfunction

    function automatic logic [DATA_W-1:0] any_byte();
        return DATA_W'($urandom_range(0, 255));
    endfunction

    // buffer holding the pattern after a random prefix; broken flips one byte of the pattern if that byte is compared
    function automatic void build_match_frame(bit broken);
        int unsigned n;
        int unsigned prefix;
        int unsigned flip_at;
        logic [DATA_W-1:0] b;
        n = used_length();
        prefix = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
        flip_at = $urandom_range(0, n - 1);
        repeat (prefix) frame_q = {frame_q, any_byte()};
        for (int unsigned i = 0; i < n; i++) begin
            b = pat_mask[i] ? pat_word[i >> 3][8 * (i & 7) +: 8] : any_byte();
            if (broken && i == flip_at && pat_mask[i])
                b = b ^ DATA_W'($urandom_range(1, 255));
            frame_q = {frame_q, b};
        end
        repeat ($urandom_range(0, 3)) frame_q = {frame_q, any_byte()};
    endfunction

    // fresh register set for a random phase, extremes mixed in
    task automatic setup_phase(bit hit_every_buffer);
        logic [CFG_W-1:0]  v;
        logic [LEN_W-1:0]  len_val;
        logic [MASK_W-1:0] mask_val;
        for (int w = 0; w < PAT_WORDS; w++) begin
            case ($urandom_range(0, 5))
                0:       v = '0;
                1:       v = '1;
                default: v = {$urandom, $urandom};
            endcase
            write_reg(mbps_pkg::t_cfg_idx'(int'(mbps_pkg::CFG_PAT0) + w), v);
        end
        case ($urandom_range(0, 5))
            0:       mask_val = '0;
            1:       mask_val = '1;
            2:       mask_val = $urandom & $urandom;   // sparse compares
            default: mask_val = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       len_val = LEN_W'(0);                               // acts as one
            1:       len_val = LEN_W'(1);
            2:       len_val = LEN_W'(PAT_BYTES);
            3:       len_val = LEN_W'($urandom_range(PAT_BYTES + 1, 63));   // clamps to 32
            4:       len_val = LEN_W'(63);
            5, 6:    len_val = LEN_W'($urandom_range(1, PAT_BYTES));
            default: len_val = LEN_W'($urandom_range(2, 6));
        endcase
        if (hit_every_buffer) begin
            // single wildcard byte: the first byte of every buffer matches
            mask_val = '0;
            len_val = LEN_W'(1);
        end
        write_reg(mbps_pkg::CFG_MASK, CFG_W'(mask_val));
        write_reg(mbps_pkg::CFG_LEN, CFG_W'(len_val));
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            2:       v = 64'hFFFF_FFFF_FFFF_FF00 | CFG_W'($urandom_range(0, 255));  // wraps
            default: v = {$urandom, $urandom};
        endcase
        write_reg(mbps_pkg::CFG_BASE, v);
        @(negedge i_clk);
    endtask

    // -------------------------------------------------------------------
    // stimulus
    // -------------------------------------------------------------------

    initial begin : stimulus
        int unsigned phase_bytes;
        int unsigned sel;
        int unsigned n;

        // shadow state matches the block after reset
        foreach (pat_word[k]) pat_word[k] = '0;
        pat_mask = '0;
        pat_len = LEN_W'(1);
        base_addr = '0;
        clear_search();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: pattern FF 00 ?? 5A, byte 2 a wildcard
        write_reg(mbps_pkg::CFG_PAT0, 64'h0000_0000_5AC3_00FF);
        write_reg(mbps_pkg::CFG_PAT1, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(mbps_pkg::CFG_PAT2, 64'h0123_4567_89AB_CDEF);
        write_reg(mbps_pkg::CFG_PAT3, 64'hFEDC_BA98_7654_3210);
        write_reg(mbps_pkg::CFG_MASK, 64'hFFFF_FFFB);
        write_reg(mbps_pkg::CFG_LEN, 64'd4);
        write_reg(mbps_pkg::CFG_BASE, 64'h1000);
        @(negedge i_clk);
        // match at offset zero, then bytes absorbed without result
        frame_q = '{8'hFF, 8'h00, 8'h77, 8'h5A, 8'h11, 8'h22};
        push_frame();
        // buffer shorter than the pattern
        frame_q = '{8'h00, 8'hFF};
        push_frame();
        // match that completes on the last byte
        frame_q = '{8'h12, 8'hFF, 8'h00, 8'h00, 8'h5A};
        push_frame();
        // near miss on the final compared byte
        frame_q = '{8'hFF, 8'h00, 8'h13, 8'h5B};
        push_frame();
        // single byte buffer
        frame_q = '{8'h5A};
        push_frame();

        // zero length acts as one, all wildcards, base address at all ones
        wait_idle();
        write_reg(mbps_pkg::CFG_LEN, 64'd0);
        write_reg(mbps_pkg::CFG_MASK, 64'd0);
        write_reg(mbps_pkg::CFG_BASE, '1);
        @(negedge i_clk);
        frame_q = '{8'h00};
        push_frame();
        frame_q = '{8'hFF, 8'hAB};
        push_frame();

        // oversized length clamps to 32: a two byte buffer cannot match
        wait_idle();
        write_reg(mbps_pkg::CFG_LEN, 64'd40);
        @(negedge i_clk);
        frame_q = '{8'hAB, 8'hCD};
        push_frame();

        // random phases, each under its own register set
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_idle();
            setup_phase(phase == 1);
            tx_calm = (phase == 1) || ($urandom_range(0, 3) == 0);
            rx_calm = (phase != 1) && ($urandom_range(0, 3) == 0);
            n = used_length();
            phase_bytes = 0;
            while (phase_bytes < ITEMS_PER_PHASE) begin
                sel = $urandom_range(0, 19);
                if (sel < 13) begin
                    build_match_frame(1'b0);
                end else if (sel < 16) begin
                    build_match_frame(1'b1);
                end else if (sel < 18) begin
                    repeat ($urandom_range(1, n + 4)) frame_q = {frame_q, any_byte()};
                end else begin
                    // too short to hold the pattern, unless the pattern is a single byte
                    repeat ($urandom_range(1, (n > 1) ? n - 1 : 1))
                        frame_q = {frame_q, any_byte()};
                end
                phase_bytes += frame_q.size();
                push_frame();
            end
            // every buffer yields a result here: hold the receiver off for a while
            if (phase == 1) hold_req++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("masked_byte_pattern_search test passed");
        else
            $display("masked_byte_pattern_search test failed");
        $finish;
    end

endmodule
